[design/stt_pkg.sv]
// Shared constants, types and command/status structs for the software timer table.
package stt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int REM_W     = 34;
    localparam int IV_W      = 32;
    localparam int EL_W      = 16;
    localparam int OWN_W     = 8;
    localparam int OP_W      = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_START  = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
    localparam logic [OP_W-1:0] OP_DETACH = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT  = 2'd1;
    localparam logic [1:0] KIND_TICK_END = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_TOO_SMALL  = 2'd1;
    localparam logic [1:0] STS_NO_FREE    = 2'd2;
    localparam logic [1:0] STS_NOT_ACTIVE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_TICK,
        ST_TICK_END
    } t_state;

    typedef enum logic [1:0] {
        RES_OP,
        RES_HIT,
        RES_END
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     do_op;
        logic     tick_step;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_tick;
        logic hit;
        logic idx_last;
    } t_dp_stat;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [3:0]       slot;
        logic [OWN_W-1:0] owner;
        logic             active;
        logic             last;
    } t_result;

endpackage

[design/stt_ctrl.sv]
// Controller state machine: sequences single-result ops and the per-slot tick sweep.
module stt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_free,
    output logic              o_out_load,
    input  stt_pkg::t_dp_stat i_stat,
    output stt_pkg::t_dp_cmd  o_cmd
);

    stt_pkg::t_state r_state;
    stt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_out_load      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.do_op     = 1'b0;
        o_cmd.tick_step = 1'b0;
        o_cmd.res_sel   = stt_pkg::RES_OP;
        case (r_state)
            stt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.in_tick ? stt_pkg::ST_TICK : stt_pkg::ST_OP;
                end
            end
            stt_pkg::ST_OP: begin
                o_cmd.res_sel = stt_pkg::RES_OP;
                if (i_out_free) begin
                    o_cmd.do_op = 1'b1;
                    o_out_load  = 1'b1;
                    n_state     = stt_pkg::ST_IDLE;
                end
            end
            stt_pkg::ST_TICK: begin
                o_cmd.res_sel = stt_pkg::RES_HIT;
                // a slot that times out waits for room in the output register
                if (!i_stat.hit || i_out_free) begin
                    o_cmd.tick_step = 1'b1;
                    o_out_load      = i_stat.hit;
                    if (i_stat.idx_last) begin
                        n_state = stt_pkg::ST_TICK_END;
                    end
                end
            end
            stt_pkg::ST_TICK_END: begin
                o_cmd.res_sel = stt_pkg::RES_END;
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = stt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stt_pkg::ST_IDLE;
            end
        endcase
    end

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stt_pkg::ST_TICK && o_cmd.tick_step && i_stat.idx_last)
        |=> (r_state == stt_pkg::ST_TICK_END))
        else $error("tick sweep did not end after last slot");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> i_out_free)
        else $error("result loaded into a full output register");

endmodule

[design/stt_dp.sv]
// Datapath: slot table, input holding registers, tick arithmetic and result formation.
module stt_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [31:0]               i_cfg_wdata,
    input  logic [2:0]                i_opcode,
    input  logic [3:0]                i_slot,
    input  logic [31:0]               i_interval,
    input  logic                      i_periodic,
    input  logic [7:0]                i_owner,
    input  logic [15:0]               i_elapsed,
    input  stt_pkg::t_dp_cmd          i_cmd,
    output stt_pkg::t_dp_stat         o_stat,
    output stt_pkg::t_result          o_result
);

    localparam int N = stt_pkg::NUM_SLOTS;
    localparam int SW = stt_pkg::SLOT_W;

    // control state
    logic [N-1:0]                 r_valid;
    logic [stt_pkg::IV_W-1:0]     r_min_ivl;
    logic [SW-1:0]                r_idx;

    // slot payload, only meaningful while valid
    logic                         r_per [N];
    logic [stt_pkg::OWN_W-1:0]    r_own [N];
    logic [stt_pkg::IV_W-1:0]     r_iv  [N];
    logic [stt_pkg::REM_W-1:0]    r_rem [N];

    // held transaction
    logic [stt_pkg::OP_W-1:0]     r_opcode;
    logic [3:0]                   r_slot;
    logic [stt_pkg::IV_W-1:0]     r_interval;
    logic                         r_periodic;
    logic [stt_pkg::OWN_W-1:0]    r_owner;
    logic [stt_pkg::EL_W-1:0]     r_elapsed;

    logic [SW-1:0]                free_idx;
    logic                         any_free;
    logic                         too_small;
    logic                         start_go;
    logic [SW-1:0]                sl_idx;
    logic                         sl_in_range;
    logic                         sl_active;
    logic [N-1:0]                 own_match;

    logic                         cur_valid;
    logic                         cur_per;
    logic [stt_pkg::REM_W:0]      diff;
    logic [stt_pkg::REM_W:0]      diff_rel;
    logic                         below_floor;
    logic                         hit;
    logic [stt_pkg::REM_W-1:0]    new_rem;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SW'(i);
                any_free = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            own_match[i] = (r_own[i] == r_owner);
        end
    end

    assign too_small   = (r_interval < r_min_ivl);
    assign start_go    = i_cmd.do_op && (r_opcode == stt_pkg::OP_START) && !too_small
                         && any_free;
    assign sl_idx      = SW'(r_slot);
    assign sl_in_range = (32'(r_slot) < 32'(N));
    assign sl_active   = sl_in_range && r_valid[sl_idx];

    // tick arithmetic on the slot under the sweep
    assign cur_valid   = r_valid[r_idx];
    assign cur_per     = r_per[r_idx];
    assign diff        = {r_rem[r_idx][stt_pkg::REM_W-1], r_rem[r_idx]}
                         - {19'b0, r_elapsed};
    assign diff_rel    = {r_rem[r_idx][stt_pkg::REM_W-1], r_rem[r_idx]}
                         + {3'b0, r_iv[r_idx]} - {19'b0, r_elapsed};
    // below -2^33: clamp to the floor, plus the interval for a periodic slot
    assign below_floor = diff[stt_pkg::REM_W] & ~diff[stt_pkg::REM_W-1];
    assign hit         = cur_valid && diff[stt_pkg::REM_W];

    always_comb begin
        if (below_floor) begin
            new_rem = cur_per ? {2'b10, r_iv[r_idx]} : {2'b10, 32'b0};
        end else if (diff[stt_pkg::REM_W] && cur_per) begin
            new_rem = diff_rel[stt_pkg::REM_W-1:0];
        end else begin
            new_rem = diff[stt_pkg::REM_W-1:0];
        end
    end

    assign o_stat.in_tick  = (i_opcode == stt_pkg::OP_TICK);
    assign o_stat.hit      = hit;
    assign o_stat.idx_last = (r_idx == SW'(N - 1));

    always_comb begin
        o_result = '0;
        o_result.last = 1'b1;
        case (i_cmd.res_sel)
            stt_pkg::RES_OP: begin
                o_result.kind = stt_pkg::KIND_ACK;
                case (r_opcode)
                    stt_pkg::OP_START: begin
                        if (too_small) begin
                            o_result.status = stt_pkg::STS_TOO_SMALL;
                        end else if (!any_free) begin
                            o_result.status = stt_pkg::STS_NO_FREE;
                        end else begin
                            o_result.slot = 4'(free_idx);
                        end
                    end
                    stt_pkg::OP_STOP: begin
                        o_result.slot   = r_slot;
                        o_result.status = sl_active ? stt_pkg::STS_OK
                                                    : stt_pkg::STS_NOT_ACTIVE;
                    end
                    stt_pkg::OP_QUERY: begin
                        o_result.slot   = r_slot;
                        o_result.active = sl_active;
                    end
                    default: begin
                    end
                endcase
            end
            stt_pkg::RES_HIT: begin
                o_result.kind  = stt_pkg::KIND_TIMEOUT;
                o_result.slot  = 4'(r_idx);
                o_result.owner = r_own[r_idx];
                o_result.last  = 1'b0;
            end
            stt_pkg::RES_END: begin
                o_result.kind = stt_pkg::KIND_TICK_END;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_min_ivl <= '0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_ivl <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.tick_step) begin
                r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.do_op) begin
                case (r_opcode)
                    stt_pkg::OP_START: begin
                        if (start_go) begin
                            r_valid[free_idx] <= 1'b1;
                        end
                    end
                    stt_pkg::OP_STOP: begin
                        if (sl_active) begin
                            r_valid[sl_idx] <= 1'b0;
                        end
                    end
                    stt_pkg::OP_DETACH: begin
                        r_valid <= r_valid & ~own_match;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tick_step && hit && !cur_per) begin
                r_valid[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode   <= i_opcode;
            r_slot     <= i_slot;
            r_interval <= i_interval;
            r_periodic <= i_periodic;
            r_owner    <= i_owner;
            r_elapsed  <= i_elapsed;
        end
        if (start_go) begin
            r_per[free_idx] <= r_periodic;
            r_own[free_idx] <= r_owner;
            r_iv[free_idx]  <= r_interval;
            r_rem[free_idx] <= {2'b00, r_interval};
        end
        if (i_cmd.tick_step && cur_valid) begin
            r_rem[r_idx] <= new_rem;
        end
    end

    a_start_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_go |=> r_valid[$past(free_idx)])
        else $error("started slot not marked valid");

    a_oneshot_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_step && hit && !cur_per) |=> !r_valid[$past(r_idx)])
        else $error("expired one-shot slot still valid");

endmodule

[design/software_timer_table.sv]
// Top level of the software timer table: controller, datapath and output register.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+--------------------------------------------
//  input     | i_in_valid / o_in_ready      | i_opcode i_slot i_interval i_periodic
//            |                              | i_owner i_elapsed
//  output    | o_out_valid / i_out_ready    | o_kind o_status o_out_slot o_out_owner
//            |                              | o_active o_last
//  config    | i_cfg_we (no wait)           | i_cfg_wdata (minimum start interval)
//
//  Start, stop, detach, query, unused opcodes: one result, registered from the ST_OP state
//  once the output register has room; the next transaction is taken back in ST_IDLE.
//  Tick: one slot per cycle over the single-port table while not stalled; the ST_TICK_END
//  state then registers the tick-finished result once the output register has room.
//  A timeout result stalls the sweep while the output register is still occupied.
//  Synchronous active-low reset clears valid marks and the minimum interval; no clearing pass.
module software_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_interval,
    input  logic        i_periodic,
    input  logic [7:0]  i_owner,
    input  logic [15:0] i_elapsed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [3:0]  o_out_slot,
    output logic [7:0]  o_out_owner,
    output logic        o_active,
    output logic        o_last
);

    stt_pkg::t_dp_cmd  cmd;
    stt_pkg::t_dp_stat stat;
    stt_pkg::t_result  result;
    logic              out_free;
    logic              out_load;

    // output register state
    logic              r_out_valid;
    stt_pkg::t_result  r_out;

    // room in the output register: empty, or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .o_out_load (out_load),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (i_opcode),
        .i_slot      (i_slot),
        .i_interval  (i_interval),
        .i_periodic  (i_periodic),
        .i_owner     (i_owner),
        .i_elapsed   (i_elapsed),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (result)
    );

    // Output register: holds one result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_status    = r_out.status;
    assign o_out_slot  = r_out.slot;
    assign o_out_owner = r_out.owner;
    assign o_active    = r_out.active;
    assign o_last      = r_out.last;

    // the last flag only ends an acknowledgement or a tick, never a timeout
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && result.kind == stt_pkg::KIND_TIMEOUT) |-> !result.last)
        else $error("timeout result flagged as last");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.tick_step || cmd.do_op) |-> !o_in_ready)
        else $error("input taken while a transaction is in progress");

endmodule
